>>> hw/rtl/cwb_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the coalescing write buffer.
// No dependencies; used by cwb_cmp and coalescing_write_buffer_core.
package cwb_pkg;

  // Default geometry
  localparam int DEPTH_DEFAULT     = 8;
  localparam int ADDR_BITS_DEFAULT = 26;

  // Match-width register
  localparam int              MATCH_W          = 5;
  localparam logic [MATCH_W-1:0] MATCH_BITS_RESET = 5'd22;

  // Input item kinds
  localparam logic KIND_WRITE  = 1'b0;
  localparam logic KIND_REMOVE = 1'b1;

  // Result item kinds
  localparam logic RES_DRAIN  = 1'b0;
  localparam logic RES_STATUS = 1'b1;

  // Sequencer states, one-hot
  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_SCAN  = 6'b000010,
    ST_DRD   = 6'b000100,
    ST_DLD   = 6'b001000,
    ST_DWAIT = 6'b010000,
    ST_SWAIT = 6'b100000
  } cwb_state_t;

endpackage

>>> hw/rtl/cwb_cmp.sv
`timescale 1ns / 1ps
// Masked block-address comparator shared by every slot of the scan.
// Depends on cwb_pkg for the match-width register size.
module cwb_cmp #(
  parameter int ADDRESS_BITS = cwb_pkg::ADDR_BITS_DEFAULT
) (
  input  logic [cwb_pkg::MATCH_W-1:0] match_bits,
  input  logic [ADDRESS_BITS-1:0]     lhs,
  input  logic [ADDRESS_BITS-1:0]     rhs,
  output logic                        hit
);
  import cwb_pkg::*;

  logic [ADDRESS_BITS-1:0] mask;

  // Top match_bits bits are compared; saturates at the full width
  always_comb begin
    for (int b = 0; b < ADDRESS_BITS; b++) begin
      mask[b] = (ADDRESS_BITS - b) <= int'(match_bits);
    end
  end

  assign hit = ((lhs ^ rhs) & mask) == '0;

endmodule

>>> hw/rtl/coalescing_write_buffer_core.sv
`timescale 1ns / 1ps
// Coalescing write buffer: top level with sequencer, entry memory and output register.
// Depends on cwb_pkg and cwb_cmp.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+---------------------------------------------
//  in_     | input     | in_valid/in_ready  | kind, address, slot
//  out_    | output    | out_valid/out_ready| res_kind, drain_address, slot_index,
//          |           |                    | coalesced, occupancy, last
//  cfg_    | input     | cfg_wr_en          | cfg_wr_data (match_bits)
//
// One item at a time: in_ready is high only while the sequencer is idle.
// Remove: status item in the cycle after acceptance. Write: one shared comparator
// scans one slot per cycle off the single memory read port, status at the end of
// the scan (earlier on a hit). A full buffer first drains every slot through the
// DRD, DLD and DWAIT states. Output stalls hold the sequencer. Reset is synchronous, active
// low, and clears all valid bits and the count; the entry memory is not cleared.
module coalescing_write_buffer_core #(
  parameter int BUFFER_DEPTH = cwb_pkg::DEPTH_DEFAULT,
  parameter int ADDRESS_BITS = cwb_pkg::ADDR_BITS_DEFAULT
) (
  input  logic                                                  clk,
  input  logic                                                  rst_n,
  input  logic                                                  cfg_wr_en,
  input  logic [cwb_pkg::MATCH_W-1:0]                           cfg_wr_data,
  input  logic                                                  in_valid,
  output logic                                                  in_ready,
  input  logic                                                  in_kind,
  input  logic [ADDRESS_BITS-1:0]                               in_address,
  input  logic [$clog2(BUFFER_DEPTH > 1 ? BUFFER_DEPTH : 2)-1:0] in_slot,
  output logic                                                  out_valid,
  input  logic                                                  out_ready,
  output logic                                                  out_res_kind,
  output logic [ADDRESS_BITS-1:0]                               out_drain_address,
  output logic [$clog2(BUFFER_DEPTH > 1 ? BUFFER_DEPTH : 2)-1:0] out_slot_index,
  output logic                                                  out_coalesced,
  output logic [$clog2(BUFFER_DEPTH + 1)-1:0]                   out_occupancy,
  output logic                                                  out_last
);
  import cwb_pkg::*;

  localparam int SLOT_W = $clog2(BUFFER_DEPTH > 1 ? BUFFER_DEPTH : 2);
  localparam int CNT_W  = $clog2(BUFFER_DEPTH + 1);
  localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(BUFFER_DEPTH - 1);

  // Control state
  cwb_state_t            state_r, state_nxt;
  logic [MATCH_W-1:0]    match_bits_r, match_bits_nxt;
  logic [BUFFER_DEPTH-1:0] valid_r, valid_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [SLOT_W-1:0]     rd_idx_r, rd_idx_nxt;
  logic                  rd_done_r, rd_done_nxt;
  logic                  cmp_vld_r, cmp_vld_nxt;
  logic [SLOT_W-1:0]     cmp_idx_r, cmp_idx_nxt;
  logic                  free_found_r, free_found_nxt;
  logic                  out_valid_r, out_valid_nxt;

  // Payload
  logic [ADDRESS_BITS-1:0] addr_r, addr_nxt;
  logic [SLOT_W-1:0]       free_idx_r, free_idx_nxt;
  logic [ADDRESS_BITS-1:0] mem_q_r;
  logic                    out_kind_r, out_kind_nxt;
  logic [ADDRESS_BITS-1:0] out_addr_r, out_addr_nxt;
  logic [SLOT_W-1:0]       out_slot_r, out_slot_nxt;
  logic                    out_coal_r, out_coal_nxt;
  logic [CNT_W-1:0]        out_occ_r, out_occ_nxt;
  logic                    out_last_r, out_last_nxt;

  // Entry memory port
  logic [ADDRESS_BITS-1:0] entry_mem [BUFFER_DEPTH];
  logic                    mem_re;
  logic                    mem_we;
  logic [SLOT_W-1:0]       mem_waddr;

  logic hit;
  logic out_fire;
  logic cur_valid;
  logic [SLOT_W-1:0] store_slot;

  // Shared comparator: memory read data against the latched write address
  cwb_cmp #(
    .ADDRESS_BITS(ADDRESS_BITS)
  ) u_cmp (
    .match_bits(match_bits_r),
    .lhs       (mem_q_r),
    .rhs       (addr_r),
    .hit       (hit)
  );

  assign out_fire  = out_valid_r && out_ready;
  assign cur_valid = valid_r[cmp_idx_r];
  assign in_ready  = (state_r == ST_IDLE);

  // Sequencer
  always_comb begin
    state_nxt      = state_r;
    match_bits_nxt = cfg_wr_en ? cfg_wr_data : match_bits_r;
    valid_nxt      = valid_r;
    count_nxt      = count_r;
    rd_idx_nxt     = rd_idx_r;
    rd_done_nxt    = rd_done_r;
    cmp_vld_nxt    = 1'b0;
    cmp_idx_nxt    = cmp_idx_r;
    free_found_nxt = free_found_r;
    free_idx_nxt   = free_idx_r;
    addr_nxt       = addr_r;
    out_valid_nxt  = out_valid_r;
    out_kind_nxt   = out_kind_r;
    out_addr_nxt   = out_addr_r;
    out_slot_nxt   = out_slot_r;
    out_coal_nxt   = out_coal_r;
    out_occ_nxt    = out_occ_r;
    out_last_nxt   = out_last_r;
    mem_re         = 1'b0;
    mem_we         = 1'b0;
    mem_waddr      = rd_idx_r;
    store_slot     = free_found_r ? free_idx_r : cmp_idx_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_kind == KIND_REMOVE) begin
            // Remove: empty slot if it is in range and occupied
            if (int'(in_slot) < BUFFER_DEPTH && valid_r[in_slot]) begin
              valid_nxt[in_slot] = 1'b0;
              count_nxt          = count_r - CNT_W'(1);
            end
            out_valid_nxt = 1'b1;
            out_kind_nxt  = RES_STATUS;
            out_addr_nxt  = '0;
            out_slot_nxt  = in_slot;
            out_coal_nxt  = 1'b0;
            out_occ_nxt   = count_nxt;
            out_last_nxt  = 1'b1;
            state_nxt     = ST_SWAIT;
          end else begin
            addr_nxt       = in_address;
            rd_idx_nxt     = '0;
            rd_done_nxt    = 1'b0;
            free_found_nxt = 1'b0;
            state_nxt      = ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        // Read stage: one slot per cycle
        if (!rd_done_r) begin
          mem_re      = 1'b1;
          cmp_vld_nxt = 1'b1;
          cmp_idx_nxt = rd_idx_r;
          if (rd_idx_r == LAST_IDX) begin
            rd_done_nxt = 1'b1;
          end else begin
            rd_idx_nxt = rd_idx_r + SLOT_W'(1);
          end
        end
        // Compare stage
        if (cmp_vld_r) begin
          if (cur_valid && hit) begin
            out_valid_nxt = 1'b1;
            out_kind_nxt  = RES_STATUS;
            out_addr_nxt  = '0;
            out_slot_nxt  = cmp_idx_r;
            out_coal_nxt  = 1'b1;
            out_occ_nxt   = count_r;
            out_last_nxt  = 1'b1;
            state_nxt     = ST_SWAIT;
          end else begin
            if (!cur_valid && !free_found_r) begin
              free_found_nxt = 1'b1;
              free_idx_nxt   = cmp_idx_r;
            end
            if (cmp_idx_r == LAST_IDX) begin
              if (free_found_r || !cur_valid) begin
                // Miss with room: store in lowest empty slot
                mem_we                = 1'b1;
                mem_waddr             = store_slot;
                valid_nxt[store_slot] = 1'b1;
                count_nxt             = count_r + CNT_W'(1);
                out_valid_nxt         = 1'b1;
                out_kind_nxt          = RES_STATUS;
                out_addr_nxt          = '0;
                out_slot_nxt          = store_slot;
                out_coal_nxt          = 1'b0;
                out_occ_nxt           = count_nxt;
                out_last_nxt          = 1'b1;
                state_nxt             = ST_SWAIT;
              end else begin
                // Miss on a full buffer: drain from slot 0
                rd_idx_nxt = '0;
                state_nxt  = ST_DRD;
              end
            end
          end
        end
      end

      ST_DRD: begin
        mem_re    = 1'b1;
        state_nxt = ST_DLD;
      end

      ST_DLD: begin
        valid_nxt[rd_idx_r] = 1'b0;
        count_nxt           = count_r - CNT_W'(1);
        out_valid_nxt       = 1'b1;
        out_kind_nxt        = RES_DRAIN;
        out_addr_nxt        = mem_q_r;
        out_slot_nxt        = rd_idx_r;
        out_coal_nxt        = 1'b0;
        out_occ_nxt         = count_nxt;
        out_last_nxt        = 1'b0;
        state_nxt           = ST_DWAIT;
      end

      ST_DWAIT: begin
        if (out_fire) begin
          out_valid_nxt = 1'b0;
          if (rd_idx_r == LAST_IDX) begin
            // Drain done: new address goes to slot 0
            mem_we        = 1'b1;
            mem_waddr     = '0;
            valid_nxt[0]  = 1'b1;
            count_nxt     = count_r + CNT_W'(1);
            out_valid_nxt = 1'b1;
            out_kind_nxt  = RES_STATUS;
            out_addr_nxt  = '0;
            out_slot_nxt  = '0;
            out_coal_nxt  = 1'b0;
            out_occ_nxt   = count_nxt;
            out_last_nxt  = 1'b1;
            state_nxt     = ST_SWAIT;
          end else begin
            rd_idx_nxt = rd_idx_r + SLOT_W'(1);
            state_nxt  = ST_DRD;
          end
        end
      end

      ST_SWAIT: begin
        if (out_fire) begin
          out_valid_nxt = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Entry memory, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      entry_mem[mem_waddr] <= addr_r;
    end
    if (mem_re) begin
      mem_q_r <= entry_mem[rd_idx_r];
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      match_bits_r <= MATCH_BITS_RESET;
      valid_r      <= '0;
      count_r      <= '0;
      rd_idx_r     <= '0;
      rd_done_r    <= 1'b0;
      cmp_vld_r    <= 1'b0;
      cmp_idx_r    <= '0;
      free_found_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      match_bits_r <= match_bits_nxt;
      valid_r      <= valid_nxt;
      count_r      <= count_nxt;
      rd_idx_r     <= rd_idx_nxt;
      rd_done_r    <= rd_done_nxt;
      cmp_vld_r    <= cmp_vld_nxt;
      cmp_idx_r    <= cmp_idx_nxt;
      free_found_r <= free_found_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    addr_r     <= addr_nxt;
    free_idx_r <= free_idx_nxt;
    out_kind_r <= out_kind_nxt;
    out_addr_r <= out_addr_nxt;
    out_slot_r <= out_slot_nxt;
    out_coal_r <= out_coal_nxt;
    out_occ_r  <= out_occ_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_res_kind      = out_kind_r;
  assign out_drain_address = out_addr_r;
  assign out_slot_index    = out_slot_r;
  assign out_coalesced     = out_coal_r;
  assign out_occupancy     = out_occ_r;
  assign out_last          = out_last_r;

endmodule

>>> tb/sv/tb_coalescing_write_buffer_core.sv
`timescale 1ns / 1ps
// Self-checking testbench for coalescing_write_buffer_core: drives writes and
// removes, predicts drain and status items in step, and checks every result.
// Depends on cwb_pkg and the coalescing_write_buffer_core RTL.
module tb_coalescing_write_buffer_core;
  import cwb_pkg::*;

  localparam int DEPTH      = DEPTH_DEFAULT;
  localparam int AW         = ADDR_BITS_DEFAULT;
  localparam int SW         = 3;
  localparam int OW         = 4;
  localparam int MAX_FAULTS = 10;
  localparam int RX_HOLD    = 300;
  localparam int SETTLE     = 40;
  localparam int LIMIT      = 600000;
  localparam int PHASE_OPS  = 60;

  typedef struct packed {
    logic          kind;
    logic [AW-1:0] addr;
    logic [SW-1:0] slot;
  } wb_op_t;

  typedef struct packed {
    logic          res_kind;
    logic [AW-1:0] drain_addr;
    logic [SW-1:0] slot;
    logic          coalesced;
    logic [OW-1:0] occupancy;
    logic          last;
  } wb_result_t;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          cfg_wr_en = 1'b0;
  logic [4:0]    cfg_wr_data = '0;
  logic          in_valid = 1'b0;
  logic          in_ready;
  logic          in_kind = 1'b0;
  logic [AW-1:0] in_address = '0;
  logic [SW-1:0] in_slot = '0;
  logic          out_valid;
  logic          out_ready = 1'b0;
  logic          out_res_kind;
  logic [AW-1:0] out_drain_address;
  logic [SW-1:0] out_slot_index;
  logic          out_coalesced;
  logic [OW-1:0] out_occupancy;
  logic          out_last;

  coalescing_write_buffer_core u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_kind          (in_kind),
    .in_address       (in_address),
    .in_slot          (in_slot),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_res_kind     (out_res_kind),
    .out_drain_address(out_drain_address),
    .out_slot_index   (out_slot_index),
    .out_coalesced    (out_coalesced),
    .out_occupancy    (out_occupancy),
    .out_last         (out_last)
  );

  // Clock, 10 ns period
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  wb_op_t        queued_ops[$];
  wb_result_t    due_results[$];
  logic [AW-1:0] recent_addrs[$];
  wb_op_t        next_op;
  logic          in_took = 1'b0;
  int            send_gap = 0;
  int            rx_gap = 0;
  int            idle_pct = 0;
  logic          hold_req = 1'b0;
  logic          rx_hold = 1'b0;
  int            fault_count = 0;
  int            cycle_count = 0;

  // Shadow of the buffer contents and the match-width register
  logic [AW-1:0] slot_addr[DEPTH];
  bit            slot_used[DEPTH];
  int            used_count = 0;
  logic [4:0]    match_width = MATCH_BITS_RESET;

  task automatic add_result(input logic rk, input logic [AW-1:0] a, input int s,
                            input logic coal, input int occ, input logic lst);
    wb_result_t r;
    r.res_kind   = rk;
    r.drain_addr = a;
    r.slot       = s[SW-1:0];
    r.coalesced  = coal;
    r.occupancy  = occ[OW-1:0];
    r.last       = lst;
    due_results.push_back(r);
  endtask

  // Work out the drain and status items one accepted item causes
  task automatic predict_op(input logic kind, input logic [AW-1:0] addr,
                            input logic [SW-1:0] slot);
    logic [AW-1:0] mask;
    int            width;
    int            hit;
    int            free;
    mask  = '0;
    hit   = -1;
    free  = -1;
    width = (match_width > AW) ? AW : match_width;
    if (kind == KIND_REMOVE) begin
      if (slot_used[slot]) begin
        slot_used[slot] = 1'b0;
        used_count--;
      end
      add_result(RES_STATUS, '0, slot, 1'b0, used_count, 1'b1);
    end else begin
      for (int b = 0; b < width; b++) mask[AW-1-b] = 1'b1;
      for (int i = 0; i < DEPTH && hit < 0; i++)
        if (slot_used[i] && ((slot_addr[i] ^ addr) & mask) == '0) hit = i;
      if (hit >= 0) begin
        add_result(RES_STATUS, '0, hit, 1'b1, used_count, 1'b1);
      end else begin
        for (int i = 0; i < DEPTH && free < 0; i++)
          if (!slot_used[i]) free = i;
        // full buffer: every slot drains out in index order first
        if (free < 0) begin
          for (int i = 0; i < DEPTH; i++) begin
            slot_used[i] = 1'b0;
            used_count--;
            add_result(RES_DRAIN, slot_addr[i], i, 1'b0, used_count, 1'b0);
          end
          free = 0;
        end
        slot_addr[free] = addr;
        slot_used[free] = 1'b1;
        used_count++;
        add_result(RES_STATUS, '0, free, 1'b0, used_count, 1'b1);
      end
    end
  endtask

  task automatic report_fault(input string why, input wb_result_t want,
                              input wb_result_t got);
    fault_count++;
    if (fault_count <= MAX_FAULTS) begin
      $display("%0t: %s: exp kind=%0d addr=%h slot=%0d coal=%0d occ=%0d last=%0d",
               $realtime, why, want.res_kind, want.drain_addr, want.slot,
               want.coalesced, want.occupancy, want.last);
      $display("%0t: %s: got kind=%0d addr=%h slot=%0d coal=%0d occ=%0d last=%0d",
               $realtime, why, got.res_kind, got.drain_addr, got.slot,
               got.coalesced, got.occupancy, got.last);
    end
  endtask

  // Monitor: predict on input handshakes, check on output handshakes
  always @(posedge clk) begin
    wb_result_t got;
    wb_result_t want;
    in_took <= rst_n && in_valid && in_ready;
    if (rst_n) begin
      if (in_valid && in_ready) predict_op(in_kind, in_address, in_slot);
      if (out_valid && out_ready) begin
        got = {out_res_kind, out_drain_address, out_slot_index, out_coalesced,
               out_occupancy, out_last};
        if (due_results.size() == 0) begin
          report_fault("result with nothing due", '0, got);
        end else begin
          want = due_results.pop_front();
          if (got !== want) report_fault("result mismatch", want, got);
        end
      end
    end
  end

  // Sender: holds an offered item until taken, then idles or offers the next
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (send_gap != 0) begin
        in_valid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (queued_ops.size() != 0) begin
        next_op = queued_ops.pop_front();
        in_valid   <= 1'b1;
        in_kind    <= next_op.kind;
        in_address <= next_op.addr;
        in_slot    <= next_op.slot;
        if ($urandom_range(0, 99) < idle_pct) send_gap <= $urandom_range(1, 12);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stall bursts plus the long hold-off
  always @(negedge clk) begin
    if (!rst_n || rx_hold) begin
      out_ready <= 1'b0;
    end else if (rx_gap != 0) begin
      out_ready <= 1'b0;
      rx_gap    <= rx_gap - 1;
    end else begin
      out_ready <= 1'b1;
      if ($urandom_range(0, 99) < idle_pct) rx_gap <= $urandom_range(1, 12);
    end
  end

  // Long receiver hold-off, counted here once requested
  initial begin
    wait (hold_req);
    rx_hold = 1'b1;
    repeat (RX_HOLD) @(posedge clk);
    rx_hold = 1'b0;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic push_op(input logic kind, input logic [AW-1:0] addr,
                         input logic [SW-1:0] slot);
    wb_op_t op;
    op.kind = kind;
    op.addr = addr;
    op.slot = slot;
    queued_ops.push_back(op);
  endtask

  // Wait until every item is taken and every result has come back
  task automatic wait_drained();
    while (queued_ops.size() != 0 || in_valid || due_results.size() != 0)
      @(posedge clk);
  endtask

  task automatic write_match_bits(input logic [4:0] value);
    wait_drained();
    @(negedge clk);
    cfg_wr_en   = 1'b1;
    cfg_wr_data = value;
    match_width = value;
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  // Mix of near-repeat writes (to hit), fresh writes (to fill and drain) and removes
  task automatic push_random_op();
    logic [31:0]   rnd;
    logic [AW-1:0] a;
    int            pick;
    rnd  = $urandom();
    a    = rnd[AW-1:0];
    pick = $urandom_range(0, 99);
    if (pick < 15) begin
      push_op(KIND_REMOVE, a, SW'($urandom_range(0, 7)));
    end else if (pick < 55 && recent_addrs.size() != 0) begin
      a = recent_addrs[$urandom_range(0, recent_addrs.size() - 1)]
          ^ AW'($urandom_range(0, 63));
      if ($urandom_range(0, 7) == 0) a[$urandom_range(0, AW - 1)] ^= 1'b1;
      push_op(KIND_WRITE, a, SW'($urandom_range(0, 7)));
    end else begin
      recent_addrs.push_back(a);
      if (recent_addrs.size() > 16) void'(recent_addrs.pop_front());
      push_op(KIND_WRITE, a, SW'($urandom_range(0, 7)));
    end
  endtask

  // Stimulus sequence
  initial begin
    logic [4:0] phase_cfg[8];
    phase_cfg = '{5'd22, 5'd26, 5'd31, 5'd4, 5'd0, 5'd1, 5'd13, 5'd22};
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: hits on ignored low bits, extremes, empty remove, fill and drain
    idle_pct = 15;
    write_match_bits(5'd22);
    push_op(KIND_WRITE,  26'h0000000, 3'd0);
    push_op(KIND_WRITE,  26'h000000F, 3'd7);
    push_op(KIND_WRITE,  26'h3FFFFFF, 3'd0);
    push_op(KIND_WRITE,  26'h3FFFFF0, 3'd0);
    push_op(KIND_REMOVE, 26'h3FFFFFF, 3'd7);
    push_op(KIND_REMOVE, 26'h0000000, 3'd0);
    push_op(KIND_WRITE,  26'h0000010, 3'd0);
    for (int k = 0; k < 6; k++) push_op(KIND_WRITE, AW'(26'h1000000 + (k << 4)), 3'd0);
    push_op(KIND_WRITE,  26'h2AAAAAA, 3'd0);
    push_op(KIND_REMOVE, 26'h0000000, 3'd0);
    push_op(KIND_WRITE,  26'h1555555, 3'd0);
    push_op(KIND_WRITE,  26'h1555565, 3'd0);

    // One compared bit: two slots match, lowest index wins
    write_match_bits(5'd1);
    push_op(KIND_WRITE,  26'h0000000, 3'd0);
    push_op(KIND_WRITE,  26'h2000000, 3'd0);
    push_op(KIND_REMOVE, 26'h0000000, 3'd0);
    push_op(KIND_WRITE,  26'h0000000, 3'd0);

    // No compared bits: any valid slot matches
    write_match_bits(5'd0);
    push_op(KIND_WRITE, 26'h3FFFFFF, 3'd0);

    // Above the address width saturates to a full compare
    write_match_bits(5'd31);
    push_op(KIND_WRITE, 26'h2000000, 3'd0);
    push_op(KIND_WRITE, 26'h2000001, 3'd0);
    write_match_bits(5'd26);
    push_op(KIND_WRITE, 26'h2000001, 3'd0);

    // Random phases, each after its own match-width write
    for (int p = 0; p < 8; p++) begin
      write_match_bits(p == 6 ? 5'($urandom_range(0, 31)) : phase_cfg[p]);
      case (p)
        0, 4:    idle_pct = 20;
        2:       idle_pct = 0;
        7:       idle_pct = 0;
        default: idle_pct = 8;
      endcase
      if (p == 1) hold_req = 1'b1;
      for (int n = 0; n < PHASE_OPS; n++) push_random_op();
    end

    wait_drained();
    repeat (SETTLE) @(posedge clk);
    if (fault_count == 0 && due_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
